// ===== rtl/core/m2i_pkg.sv =====
// Package for the 2x2 matrix inverse block: widths, pipeline payload types.
// No dependencies; imported by every module of the block.
`default_nettype none
package m2i_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ELEM_WIDTH = 32;
    localparam int PROD_WIDTH = 2 * ELEM_WIDTH;
    localparam int DIV_STEPS  = 2 * FRAC_BITS;
    localparam int LANES      = 4;

    localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // Configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_FB_00     = 3'd1;
    localparam logic [2:0] CFG_FB_10     = 3'd2;
    localparam logic [2:0] CFG_FB_01     = 3'd3;
    localparam logic [2:0] CFG_FB_11     = 3'd4;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0]             thr;
        logic [LANES-1:0][ELEM_WIDTH-1:0]  fb;
    } cfg_t;

    // One divider lane: numerator sign, overflow, partial remainder, quotient
    typedef struct packed {
        logic                  neg;
        logic                  ovf;
        logic [PROD_WIDTH-1:0] rem;
        logic [ELEM_WIDTH-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic                  vld;
        logic                  sing;
        logic                  dneg;
        logic [PROD_WIDTH-1:0] dmag;
        lane_t [LANES-1:0]     lane;
    } div_t;

    typedef struct packed {
        logic                             vld;
        logic [LANES-1:0][ELEM_WIDTH-1:0] inv;
        logic                             sing;
        logic                             sat;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/m2i_in_if.sv =====
// Input matrix channel: valid/ready plus four Q16.16 elements.
// No dependencies.
`default_nettype none
interface m2i_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m10;
    logic signed [31:0] m01;
    logic signed [31:0] m11;
    modport source(output valid, m00, m10, m01, m11, input ready);
    modport sink(input valid, m00, m10, m01, m11, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/m2i_out_if.sv =====
// Result channel: valid/ready plus inverse elements and status flags.
// No dependencies.
`default_nettype none
interface m2i_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] inv00;
    logic signed [31:0] inv10;
    logic signed [31:0] inv01;
    logic signed [31:0] inv11;
    logic               singular;
    logic               saturated;
    modport source(output valid, inv00, inv10, inv01, inv11, singular, saturated,
                   input ready);
    modport sink(input valid, inv00, inv10, inv01, inv11, singular, saturated,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/core/m2i_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// No dependencies.
`default_nettype none
interface m2i_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mat2_inverse_with_fallback.sv =====
// Pipeline: an accepted beat passes 4 front stages, 32 divider stages and
// 1 output stage. Throughput: one matrix per cycle unless the output stalls;
// the 32-stage restoring divider, one quotient bit per stage, sets the depth.
// All stages advance together; they hold while a result waits at the output.
// Reset (rst_n, async, active low) clears every stage valid bit and loads the
// threshold and fallback registers with their defaults (4295, identity).
`default_nettype none
module mat2_inverse_with_fallback
    import m2i_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    m2i_in_if.sink     src,
    m2i_out_if.source  res,
    m2i_cfg_if.sink    cfg
);

    cfg_t cfg_reg;
    logic adv;
    div_t front_out;
    div_t div_pipe [DIV_STEPS+1];
    res_t back_out;

    // Advance the whole pipeline unless the output beat is stalled.
    assign adv       = !back_out.vld || res.ready;
    assign src.ready = adv;
    assign cfg.ready = 1'b1;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thr   <= 32'd4295;
            cfg_reg.fb[0] <= 32'd65536;
            cfg_reg.fb[1] <= '0;
            cfg_reg.fb[2] <= '0;
            cfg_reg.fb[3] <= 32'd65536;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_THRESHOLD: cfg_reg.thr   <= cfg.data;
                CFG_FB_00:     cfg_reg.fb[0] <= cfg.data;
                CFG_FB_10:     cfg_reg.fb[1] <= cfg.data;
                CFG_FB_01:     cfg_reg.fb[2] <= cfg.data;
                CFG_FB_11:     cfg_reg.fb[3] <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Products, determinant, magnitude and singular test.
    m2i_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (src.valid),
        .a00    (src.m00),
        .a10    (src.m10),
        .a01    (src.m01),
        .a11    (src.m11),
        .thr    (cfg_reg.thr),
        .out    (front_out)
    );

    assign div_pipe[0] = front_out;

    // One quotient bit per stage for all four adjugate elements.
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        m2i_div_step u_step (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .din   (div_pipe[g]),
            .dout  (div_pipe[g+1])
        );
    end

    // Sign, saturate, select fallback, register the result beat.
    m2i_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .din   (div_pipe[DIV_STEPS]),
        .cfg   (cfg_reg),
        .dout  (back_out)
    );

    assign res.valid     = back_out.vld;
    assign res.inv00     = back_out.inv[0];
    assign res.inv10     = back_out.inv[1];
    assign res.inv01     = back_out.inv[2];
    assign res.inv11     = back_out.inv[3];
    assign res.singular  = back_out.sing;
    assign res.saturated = back_out.sat;

    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.singular |-> !res.saturated)
        else $error("singular result flagged saturated");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.saturated |->
            (back_out.inv[0] == ELEM_MAX) || (back_out.inv[0] == ELEM_MIN) ||
            (back_out.inv[1] == ELEM_MAX) || (back_out.inv[1] == ELEM_MIN) ||
            (back_out.inv[2] == ELEM_MAX) || (back_out.inv[2] == ELEM_MIN) ||
            (back_out.inv[3] == ELEM_MAX) || (back_out.inv[3] == ELEM_MIN))
        else $error("saturated result holds no clipped element");

    a_stall_keeps_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !src.ready |=> res.valid)
        else $error("stalled output beat lost");

endmodule
`default_nettype wire

// ===== rtl/core/m2i_front.sv =====
// Front end: products, determinant, magnitude, singular test, divider setup.
// Depends on m2i_pkg. Four register stages.
`default_nettype none
module m2i_front
    import m2i_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_vld,
    input  wire logic [ELEM_WIDTH-1:0] a00,
    input  wire logic [ELEM_WIDTH-1:0] a10,
    input  wire logic [ELEM_WIDTH-1:0] a01,
    input  wire logic [ELEM_WIDTH-1:0] a11,
    input  wire logic [ELEM_WIDTH-1:0] thr,
    output div_t                       out
);

    // stage 1: products, numerator magnitudes and signs
    logic                                  s1_vld_reg;
    logic signed [PROD_WIDTH-1:0]          s1_p0_reg, s1_p1_reg;
    logic [LANES-1:0][ELEM_WIDTH-1:0]      s1_mag_reg, s1_mag_next;
    logic [LANES-1:0]                      s1_neg_reg, s1_neg_next;
    // stage 2: determinant
    logic                                  s2_vld_reg;
    logic signed [PROD_WIDTH-1:0]          s2_det_reg;
    logic [LANES-1:0][ELEM_WIDTH-1:0]      s2_mag_reg;
    logic [LANES-1:0]                      s2_neg_reg;
    // stage 3: determinant magnitude
    logic                                  s3_vld_reg;
    logic                                  s3_dneg_reg;
    logic [PROD_WIDTH-1:0]                 s3_dmag_reg;
    logic [LANES-1:0][ELEM_WIDTH-1:0]      s3_mag_reg;
    logic [LANES-1:0]                      s3_neg_reg;
    // stage 4: divider entry
    div_t                                  s4_reg, s4_next;

    function automatic logic [ELEM_WIDTH-1:0] mag_of(input logic [ELEM_WIDTH-1:0] x);
        mag_of = x[ELEM_WIDTH-1] ? (~x + 1'b1) : x;
    endfunction

    // lane order follows the output: inv00=a11, inv10=-a10, inv01=-a01, inv11=a00
    always_comb
    begin
        s1_mag_next[0] = mag_of(a11);
        s1_mag_next[1] = mag_of(a10);
        s1_mag_next[2] = mag_of(a01);
        s1_mag_next[3] = mag_of(a00);
        s1_neg_next[0] = a11[ELEM_WIDTH-1];
        s1_neg_next[1] = !a10[ELEM_WIDTH-1] && (a10 != '0);
        s1_neg_next[2] = !a01[ELEM_WIDTH-1] && (a01 != '0);
        s1_neg_next[3] = a00[ELEM_WIDTH-1];
    end

    always_comb
    begin
        s4_next      = '0;
        s4_next.vld  = s3_vld_reg;
        s4_next.dneg = s3_dneg_reg;
        s4_next.dmag = s3_dmag_reg;
        s4_next.sing = (s3_dmag_reg == '0) ||
                       (s3_dmag_reg < {{(PROD_WIDTH-ELEM_WIDTH){1'b0}}, thr});
        for (int i = 0; i < LANES; i++)
        begin
            s4_next.lane[i].neg = s3_neg_reg[i];
            s4_next.lane[i].rem = {{(PROD_WIDTH-ELEM_WIDTH){1'b0}}, s3_mag_reg[i]};
            s4_next.lane[i].ovf = ({{(PROD_WIDTH-ELEM_WIDTH){1'b0}}, s3_mag_reg[i]}
                                   >= s3_dmag_reg);
            s4_next.lane[i].quo = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_reg     <= '0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_reg     <= s4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_p0_reg   <= PROD_WIDTH'($signed(a00) * $signed(a11));
            s1_p1_reg   <= PROD_WIDTH'($signed(a01) * $signed(a10));
            s1_mag_reg  <= s1_mag_next;
            s1_neg_reg  <= s1_neg_next;
            s2_det_reg  <= s1_p0_reg - s1_p1_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_neg_reg  <= s1_neg_reg;
            s3_dneg_reg <= s2_det_reg[PROD_WIDTH-1];
            s3_dmag_reg <= s2_det_reg[PROD_WIDTH-1] ? PROD_WIDTH'(-s2_det_reg)
                                                    : PROD_WIDTH'(s2_det_reg);
            s3_mag_reg  <= s2_mag_reg;
            s3_neg_reg  <= s2_neg_reg;
        end
    end

    assign out = s4_reg;

endmodule
`default_nettype wire

// ===== rtl/core/m2i_div_step.sv =====
// One restoring-division stage: one quotient bit for each of the four lanes.
// Depends on m2i_pkg.
`default_nettype none
module m2i_div_step
    import m2i_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  div_t      din,
    output div_t      dout
);

    div_t dout_reg, dout_next;

    always_comb
    begin
        logic [PROD_WIDTH:0]   rem2;
        logic [PROD_WIDTH+1:0] diff;
        dout_next = din;
        for (int i = 0; i < LANES; i++)
        begin
            rem2 = {din.lane[i].rem, 1'b0};
            diff = {1'b0, rem2} - {2'b00, din.dmag};
            // remainder stays below the divisor, so the kept value fits
            dout_next.lane[i].rem = diff[PROD_WIDTH+1] ? rem2[PROD_WIDTH-1:0]
                                                       : diff[PROD_WIDTH-1:0];
            dout_next.lane[i].quo = {din.lane[i].quo[ELEM_WIDTH-2:0],
                                     !diff[PROD_WIDTH+1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (adv)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

// ===== rtl/core/m2i_back.sv =====
// Back end: sign, saturation, fallback select and output register.
// Depends on m2i_pkg.
`default_nettype none
module m2i_back
    import m2i_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  div_t      din,
    input  cfg_t      cfg,
    output res_t      dout
);

    res_t dout_reg, dout_next;

    always_comb
    begin
        logic [LANES-1:0] sat;
        logic             neg;
        logic [ELEM_WIDTH-1:0] q;
        dout_next     = '0;
        dout_next.vld = din.vld;
        sat           = '0;
        for (int i = 0; i < LANES; i++)
        begin
            q   = din.lane[i].quo;
            neg = (din.lane[i].neg != din.dneg) && (din.lane[i].ovf || (q != '0));
            if (neg)
            begin
                sat[i] = din.lane[i].ovf || (q > ELEM_MIN);
                dout_next.inv[i] = sat[i] ? ELEM_MIN : (~q + 1'b1);
            end
            else
            begin
                sat[i] = din.lane[i].ovf || q[ELEM_WIDTH-1];
                dout_next.inv[i] = sat[i] ? ELEM_MAX : q;
            end
        end
        dout_next.sing = din.sing;
        if (din.sing)
        begin
            dout_next.inv = cfg.fb;
            dout_next.sat = 1'b0;
        end
        else
            dout_next.sat = |sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (adv)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire
